>>> rtl/abp_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and fixed-point helpers for the binomial pricer.
// Used by every module of the block; depends on nothing.
package abp_pkg;

  localparam logic [31:0] PRICE_MAX = 32'hFFFF_FFFF;
  localparam logic [30:0] Q30_ONE   = 31'h4000_0000;
  localparam logic [63:0] Q30_HALF  = 64'h0000_0000_2000_0000;

  typedef enum logic [2:0] {
    REG_UP    = 3'd0,
    REG_DOWN  = 3'd1,
    REG_PROB  = 3'd2,
    REG_DISC  = 3'd3,
    REG_STEPS = 3'd4
  } reg_idx_t;

  // Effective (clamped) configuration seen by the datapath.
  typedef struct packed {
    logic [31:0] up;
    logic [31:0] down;
    logic [30:0] prob;
    logic [30:0] prob_c;
    logic [30:0] disc;
  } cfg_t;

  // One write into both rows at a shared address.
  typedef struct packed {
    logic        valid;
    logic [31:0] stock;
    logic [31:0] value;
  } row_wr_t;

  // Q30 rounding (half up) of a product, saturated to the price range.
  function automatic logic [31:0] round_sat(input logic [63:0] prod);
    logic [63:0] sum;
    sum = prod + Q30_HALF;
    if (sum[63:62] != 2'b00) begin
      return PRICE_MAX;
    end
    return sum[61:30];
  endfunction

  function automatic logic [31:0] intrinsic(input logic [31:0] s, input logic [31:0] k,
                                            input logic call);
    if (call) begin
      return (s > k) ? (s - k) : 32'd0;
    end
    return (k > s) ? (k - s) : 32'd0;
  endfunction

endpackage

>>> rtl/abp_regs.sv
`timescale 1ns / 1ps
// APB configuration registers with clamping of steps, probability and discount.
// Depends on abp_pkg.
module abp_regs #(
  parameter int MAX_STEPS = 256
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [4:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output abp_pkg::cfg_t                      cfg,
  output logic [$clog2(MAX_STEPS+1)-1:0]     steps
);
  import abp_pkg::*;

  localparam int AW = $clog2(MAX_STEPS + 1);

  logic [31:0] up_factor;
  logic [31:0] down_factor;
  logic [30:0] up_probability;
  logic [30:0] step_discount;
  logic [8:0]  tree_steps;
  reg_idx_t    idx;
  logic [30:0] prob_eff;

  assign idx = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      up_factor      <= 32'h4000_0000;
      down_factor    <= 32'h4000_0000;
      up_probability <= 31'h2000_0000;
      step_discount  <= 31'h4000_0000;
      tree_steps     <= 9'd64;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_UP:    up_factor      <= pwdata;
        REG_DOWN:  down_factor    <= pwdata;
        REG_PROB:  up_probability <= pwdata[30:0];
        REG_DISC:  step_discount  <= pwdata[30:0];
        REG_STEPS: tree_steps     <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_UP:    prdata = up_factor;
      REG_DOWN:  prdata = down_factor;
      REG_PROB:  prdata = {1'b0, up_probability};
      REG_DISC:  prdata = {1'b0, step_discount};
      REG_STEPS: prdata = {23'd0, tree_steps};
      default:   prdata = 32'd0;
    endcase
  end

  assign prob_eff   = (up_probability > Q30_ONE) ? Q30_ONE : up_probability;
  assign cfg.up     = up_factor;
  assign cfg.down   = down_factor;
  assign cfg.prob   = prob_eff;
  assign cfg.prob_c = Q30_ONE - prob_eff;
  assign cfg.disc   = (step_discount > Q30_ONE) ? Q30_ONE : step_discount;

  always_comb begin
    priority if (tree_steps == 9'd0) begin
      steps = AW'(1);
    end else if (32'(tree_steps) > 32'(MAX_STEPS)) begin
      steps = AW'(MAX_STEPS);
    end else begin
      steps = AW'(tree_steps);
    end
  end

endmodule

>>> rtl/abp_rows.sv
`timescale 1ns / 1ps
// Value and stock row memories: one shared write port, registered reads
// (two on the value row, one on the stock row). Depends on abp_pkg.
module abp_rows #(
  parameter int MAX_STEPS = 256
) (
  input  logic                           clk,
  input  abp_pkg::row_wr_t               wr,
  input  logic [$clog2(MAX_STEPS+1)-1:0] wr_addr,
  input  logic [$clog2(MAX_STEPS+1)-1:0] rd_addr_lo,
  input  logic [$clog2(MAX_STEPS+1)-1:0] rd_addr_hi,
  output logic [31:0]                    rd_value_lo,
  output logic [31:0]                    rd_value_hi,
  output logic [31:0]                    rd_stock
);
  import abp_pkg::*;

  localparam int DEPTH = MAX_STEPS + 1;

  logic [31:0] value_mem [DEPTH];
  logic [31:0] stock_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.valid) begin
      value_mem[wr_addr] <= wr.value;
      stock_mem[wr_addr] <= wr.stock;
    end
    rd_value_lo <= value_mem[rd_addr_lo];
    rd_value_hi <= value_mem[rd_addr_hi];
    rd_stock    <= stock_mem[rd_addr_lo];
  end

endmodule

>>> rtl/abp_node_pipe.sv
`timescale 1ns / 1ps
// Node update pipeline: expected value, discount, stock step and early-exercise
// max, one node per cycle. Depends on abp_pkg; fed by abp_rows read data.
module abp_node_pipe #(
  parameter int MAX_STEPS = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           issue,
  input  logic [$clog2(MAX_STEPS+1)-1:0] issue_node,
  input  abp_pkg::cfg_t                  cfg,
  input  logic [31:0]                    strike,
  input  logic                           call,
  input  logic [31:0]                    rd_value_lo,
  input  logic [31:0]                    rd_value_hi,
  input  logic [31:0]                    rd_stock,
  output abp_pkg::row_wr_t               wr,
  output logic [$clog2(MAX_STEPS+1)-1:0] wr_addr,
  output logic                           busy
);
  import abp_pkg::*;

  localparam int AW = $clog2(MAX_STEPS + 1);

  logic          v1, v2, v3, v4;
  logic [AW-1:0] k1, k2, k3, k4;
  logic [63:0]   pa, pb, ps, ph;
  logic [31:0]   m, snew, s4, ex;
  logic [63:0]   msum, hsum;
  logic [31:0]   hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  assign msum = pa + pb + Q30_HALF;

  always_ff @(posedge clk) begin
    k1   <= issue_node;
    k2   <= k1;
    k3   <= k2;
    k4   <= k3;
    pa   <= 64'(cfg.prob) * 64'(rd_value_hi);
    pb   <= 64'(cfg.prob_c) * 64'(rd_value_lo);
    ps   <= 64'(rd_stock) * 64'(cfg.up);
    m    <= msum[61:30];
    snew <= round_sat(ps);
    ph   <= 64'(m) * 64'(cfg.disc);
    ex   <= intrinsic(snew, strike, call);
    s4   <= snew;
  end

  assign hsum     = ph + Q30_HALF;
  assign hold     = hsum[61:30];
  assign wr.valid = v4;
  assign wr.stock = s4;
  assign wr.value = (ex > hold) ? ex : hold;
  assign wr_addr  = k4;
  assign busy     = v1 | v2 | v3 | v4;

endmodule

>>> rtl/american_option_binomial_pricer.sv
`timescale 1ns / 1ps
// Top level of the binomial pricer: request sequencer, leaf generation, output register.
// Depends on abp_pkg, abp_regs, abp_rows and abp_node_pipe.

// Prices one American option per request on a Cox-Ross-Rubinstein tree of N steps
// (tree_steps, clamped to 1..MAX_STEPS). The down-factor power and the leaf row are
// built with one multiplier, each multiply followed by a rounding step, then backward
// induction issues one node per cycle into a pipeline over the row memories, which
// drains between levels. The next request is taken once the previous result is in the
// output register; configuration may be written only while no request is in flight.
module american_option_binomial_pricer #(
  parameter int MAX_STEPS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] spot_price,
  input  logic [31:0] strike_price,
  input  logic        is_call,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] option_price
);
  import abp_pkg::*;

  localparam int AW = $clog2(MAX_STEPS + 1);

  typedef enum logic [8:0] {
    IDLE     = 9'b000000001,
    DOWN_MUL = 9'b000000010,
    DOWN_RND = 9'b000000100,
    LEAF_WR  = 9'b000001000,
    UP_MUL   = 9'b000010000,
    UP_RND   = 9'b000100000,
    ISSUE    = 9'b001000000,
    DRAIN    = 9'b010000000,
    DONE     = 9'b100000000
  } state_t;

  state_t        state;
  cfg_t          cfg;
  logic [AW-1:0] steps;
  logic [31:0]   s;
  logic [63:0]   prod;
  logic [AW-1:0] cnt;
  logic          second;
  logic [AW-1:0] level;
  logic [AW-1:0] node;
  logic [AW-1:0] lvl;
  logic [AW:0]   node_inc;
  logic [31:0]   strike;
  logic          call;
  logic [31:0]   root;
  logic          issue;
  logic          busy;
  row_wr_t       pipe_wr;
  logic [AW-1:0] pipe_addr;
  row_wr_t       row_wr;
  logic [AW-1:0] row_addr;
  logic [AW-1:0] rd_addr_hi;
  logic [31:0]   rd_value_lo;
  logic [31:0]   rd_value_hi;
  logic [31:0]   rd_stock;

  assign pready = 1'b1;

  abp_regs #(.MAX_STEPS(MAX_STEPS)) u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg),
    .steps   (steps)
  );

  assign in_stall   = (state != IDLE);
  assign issue      = (state == ISSUE);
  assign lvl        = level - 1'b1;
  assign node_inc   = {1'b0, node} + 1'b1;
  assign rd_addr_hi = node_inc[AW-1:0];

  always_comb begin
    if (state == LEAF_WR) begin
      row_wr.valid = 1'b1;
      row_wr.stock = s;
      row_wr.value = intrinsic(s, strike, call);
      row_addr     = cnt;
    end else begin
      row_wr   = pipe_wr;
      row_addr = pipe_addr;
    end
  end

  abp_rows #(.MAX_STEPS(MAX_STEPS)) u_rows (
    .clk         (clk),
    .wr          (row_wr),
    .wr_addr     (row_addr),
    .rd_addr_lo  (node),
    .rd_addr_hi  (rd_addr_hi),
    .rd_value_lo (rd_value_lo),
    .rd_value_hi (rd_value_hi),
    .rd_stock    (rd_stock)
  );

  abp_node_pipe #(.MAX_STEPS(MAX_STEPS)) u_pipe (
    .clk         (clk),
    .rst         (rst),
    .issue       (issue),
    .issue_node  (node),
    .cfg         (cfg),
    .strike      (strike),
    .call        (call),
    .rd_value_lo (rd_value_lo),
    .rd_value_hi (rd_value_hi),
    .rd_stock    (rd_stock),
    .wr          (pipe_wr),
    .wr_addr     (pipe_addr),
    .busy        (busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      cnt       <= '0;
      second    <= 1'b0;
      level     <= '0;
      node      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_valid) begin
            cnt   <= '0;
            state <= DOWN_MUL;
          end
        end
        DOWN_MUL: begin
          if (cnt == steps) begin
            cnt   <= '0;
            state <= LEAF_WR;
          end else begin
            state <= DOWN_RND;
          end
        end
        DOWN_RND: begin
          cnt   <= cnt + 1'b1;
          state <= DOWN_MUL;
        end
        LEAF_WR: begin
          second <= 1'b0;
          if (cnt == steps) begin
            level <= steps;
            node  <= '0;
            state <= ISSUE;
          end else begin
            cnt   <= cnt + 1'b1;
            state <= UP_MUL;
          end
        end
        UP_MUL: begin
          state <= UP_RND;
        end
        UP_RND: begin
          second <= ~second;
          state  <= second ? LEAF_WR : UP_MUL;
        end
        ISSUE: begin
          if (node == lvl) begin
            node  <= '0;
            level <= lvl;
            state <= DRAIN;
          end else begin
            node <= node + 1'b1;
          end
        end
        DRAIN: begin
          if (!busy) begin
            state <= (level == '0) ? DONE : ISSUE;
          end
        end
        DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            state     <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    if (state == IDLE && in_valid) begin
      s      <= spot_price;
      strike <= strike_price;
      call   <= is_call;
    end
    if (state == DOWN_MUL) begin
      prod <= 64'(s) * 64'(cfg.down);
    end
    if (state == UP_MUL) begin
      prod <= 64'(s) * 64'(cfg.up);
    end
    if (state == DOWN_RND || state == UP_RND) begin
      s <= round_sat(prod);
    end
    if (pipe_wr.valid) begin
      root <= pipe_wr.value;
    end
    if (state == DONE && (!out_valid || !out_stall)) begin
      option_price <= root;
    end
  end

endmodule

>>> test/tb_american_option_binomial_pricer.sv
`timescale 1ns / 1ps
// Self-checking testbench for american_option_binomial_pricer: APB register setup, priced
// requests under random handshake gaps, results checked against a built-in tree model.
// Depends on abp_pkg and the RTL of the pricer.

typedef struct {
  logic [31:0] spot;
  logic [31:0] strike;
  logic        call;
  logic [31:0] price;
} priced_req_t;

class price_board;
  localparam int TREE_MAX = 256;

  logic [31:0] up_f;
  logic [31:0] down_f;
  logic [30:0] prob_r;
  logic [30:0] disc_r;
  logic [8:0]  steps_r;
  logic [31:0] stock_v[TREE_MAX + 1];
  logic [31:0] worth_v[TREE_MAX + 1];
  priced_req_t price_q[$];
  int          failures;
  int          checked;

  function new();
    up_f     = 32'h4000_0000;
    down_f   = 32'h4000_0000;
    prob_r   = 31'h2000_0000;
    disc_r   = 31'h4000_0000;
    steps_r  = 9'd64;
    failures = 0;
    checked  = 0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [31:0] data);
    case (abp_pkg::reg_idx_t'(idx))
      abp_pkg::REG_UP:    up_f    = data;
      abp_pkg::REG_DOWN:  down_f  = data;
      abp_pkg::REG_PROB:  prob_r  = data[30:0];
      abp_pkg::REG_DISC:  disc_r  = data[30:0];
      abp_pkg::REG_STEPS: steps_r = data[8:0];
      default: ;
    endcase
  endfunction

  static function logic [31:0] mul_q30(logic [31:0] a, logic [31:0] f);
    logic [63:0] r;
    r = ({32'd0, a} * {32'd0, f} + abp_pkg::Q30_HALF) >> 30;
    return (r > {32'd0, abp_pkg::PRICE_MAX}) ? abp_pkg::PRICE_MAX : r[31:0];
  endfunction

  static function logic [31:0] payoff(logic [31:0] s, logic [31:0] k, logic call);
    if (call) begin
      return (s > k) ? s - k : 32'd0;
    end
    return (k > s) ? k - s : 32'd0;
  endfunction

  function logic [31:0] root_price(logic [31:0] spot, logic [31:0] strike, logic call);
    int          n;
    int          i;
    int          lv;
    int          k;
    logic [63:0] p;
    logic [63:0] d;
    logic [63:0] one;
    logic [63:0] m;
    logic [63:0] hold;
    logic [31:0] s;
    logic [31:0] ex;
    n = steps_r;
    if (n < 1) n = 1;
    if (n > TREE_MAX) n = TREE_MAX;
    one = {33'd0, abp_pkg::Q30_ONE};
    p = {33'd0, prob_r};
    d = {33'd0, disc_r};
    if (p > one) p = one;
    if (d > one) d = one;
    s = spot;
    for (i = 0; i < n; i++) s = mul_q30(s, down_f);
    for (i = 0; i <= n; i++) begin
      if (i > 0) s = mul_q30(mul_q30(s, up_f), up_f);
      stock_v[i] = s;
      worth_v[i] = payoff(s, strike, call);
    end
    for (lv = n - 1; lv >= 0; lv--) begin
      for (k = 0; k <= lv; k++) begin
        m = (p * {32'd0, worth_v[k + 1]} + (one - p) * {32'd0, worth_v[k]}
             + abp_pkg::Q30_HALF) >> 30;
        hold = (m * d + abp_pkg::Q30_HALF) >> 30;
        stock_v[k] = mul_q30(stock_v[k], up_f);
        ex = payoff(stock_v[k], strike, call);
        worth_v[k] = ({32'd0, ex} > hold) ? ex : hold[31:0];
      end
    end
    return worth_v[0];
  endfunction

  function void note_request(logic [31:0] spot, logic [31:0] strike, logic call);
    priced_req_t r;
    r.spot   = spot;
    r.strike = strike;
    r.call   = call;
    r.price  = root_price(spot, strike, call);
    price_q.push_back(r);
  endfunction

  function void check_price(logic [31:0] got);
    priced_req_t r;
    if (price_q.size() == 0) begin
      failures++;
      if (failures <= 10) $display("unexpected option_price %h", got);
      return;
    end
    r = price_q.pop_front();
    checked++;
    if (got !== r.price) begin
      failures++;
      if (failures <= 10) begin
        $display("option_price mismatch spot=%h strike=%h call=%b: expected %h, got %h",
                 r.spot, r.strike, r.call, r.price, got);
      end
    end
  endfunction

  function int pending();
    return price_q.size();
  endfunction
endclass

module tb_american_option_binomial_pricer;
  import abp_pkg::*;

  localparam int          TREE_DEPTH  = 256;
  localparam int          STALL_LIMIT = 200000;
  localparam logic [4:0]  UNUSED_ADDR = 5'd24;
  localparam logic [31:0] Q30_UNIT    = 32'h4000_0000;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] spot_price;
  logic [31:0] strike_price;
  logic        is_call;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] option_price;

  price_board board;
  bit         no_gaps = 1'b0;
  int         hold_cnt = 0;
  int         idle_cycles = 0;
  int         tree_settings = 0;

  american_option_binomial_pricer #(.MAX_STEPS(TREE_DEPTH)) u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .spot_price(spot_price), .strike_price(strike_price), .is_call(is_call),
    .out_valid(out_valid), .out_stall(out_stall), .option_price(option_price)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // result side: check each transfer, then stall at random unless no_gaps is set
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_cnt = 0;
    end else begin
      if (out_valid && !out_stall) begin
        board.check_price(option_price);
        hold_cnt = no_gaps ? 0 : $urandom_range(0, 8);
      end
      if (hold_cnt > 0) begin
        out_stall <= 1'b1;
        hold_cnt--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [4:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    board.set_reg(addr[4:2], data);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_tree(input logic [31:0] up, input logic [31:0] down,
                          input logic [31:0] prob, input logic [31:0] disc,
                          input logic [31:0] steps);
    write_reg({REG_UP, 2'b00}, up);
    write_reg({REG_DOWN, 2'b00}, down);
    write_reg({REG_PROB, 2'b00}, prob);
    write_reg({REG_DISC, 2'b00}, disc);
    write_reg({REG_STEPS, 2'b00}, steps);
    tree_settings++;
  endtask

  // leaves in_valid high after the transfer; drop_valid lowers it
  task automatic send_request(input logic [31:0] s, input logic [31:0] k, input logic c);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    spot_price   <= s;
    strike_price <= k;
    is_call      <= c;
    in_valid     <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_request(s, k, c);
  endtask

  task automatic drop_valid();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    drop_valid();
    while (board.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_factor(input bit upward);
    if ($urandom_range(0, 4) == 0) return $urandom();
    return upward ? Q30_UNIT + $urandom_range(0, 1 << 26)
                  : Q30_UNIT - $urandom_range(0, 1 << 26);
  endfunction

  function automatic logic [31:0] pick_unit();
    if ($urandom_range(0, 5) == 0) return $urandom();
    return $urandom_range(0, 1 << 30);
  endfunction

  initial begin
    int          sent;
    int          count;
    logic [31:0] steps;
    logic [31:0] s;
    logic [31:0] k;
    board        = new();
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_valid     = 1'b0;
    spot_price   = '0;
    strike_price = '0;
    is_call      = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: flat 64-step tree, price extremes
    send_request(32'h0, 32'h0, 1'b1);
    send_request(32'hFFFF_FFFF, 32'h0, 1'b1);
    send_request(32'h0, 32'hFFFF_FFFF, 1'b0);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_request(32'h0064_0000, 32'h005A_0000, 1'b1);
    send_request(32'h0064_0000, 32'h005A_0000, 1'b0);
    settle();

    // realistic tree, early exercise of deep puts
    set_tree(32'h4147_AE14, 32'h3EC4_EC4F, 32'h2100_0000, 32'h3FFF_0000, 32'd8);
    send_request(32'h0064_0000, 32'h0064_0000, 1'b0);
    send_request(32'h0064_0000, 32'h0064_0000, 1'b1);
    send_request(32'h0064_0000, 32'h008C_0000, 1'b0);
    send_request(32'h0001_0000, 32'h0064_0000, 1'b0);
    settle();

    // saturating factors, probability and discount above one
    set_tree(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd16);
    send_request(32'h8000_0000, 32'h0010_0000, 1'b1);
    send_request(32'hFFFF_FFFF, 32'h0, 1'b1);
    send_request(32'h0000_0001, 32'hFFFF_FFFF, 1'b0);
    settle();

    // zero factors, zero steps, writes to an unused address
    write_reg(UNUSED_ADDR, 32'hFFFF_FFFF);
    set_tree(32'h0, 32'h0, 32'h0, 32'h0, 32'd0);
    send_request(32'h1234_5678, 32'h0000_1000, 1'b1);
    send_request(32'h1234_5678, 32'h0001_0000, 1'b0);
    settle();
    write_reg(UNUSED_ADDR, 32'h0000_0003);
    send_request(32'h8765_4321, 32'h0000_0001, 1'b0);
    settle();

    // steps above the maximum, then the maximum itself
    no_gaps = 1'b1;
    set_tree(32'h4010_0000, 32'h3FF0_0000, 32'h2000_0000, 32'h3FFF_F000, 32'd511);
    send_request(32'h0064_0000, 32'h0064_0000, 1'b0);
    send_request(32'h0032_0000, 32'h0064_0000, 1'b1);
    settle();
    no_gaps = 1'b0;
    write_reg({REG_STEPS, 2'b00}, 32'd256);
    send_request(32'h0064_0000, 32'h0070_0000, 1'b0);
    send_request(32'hFFFF_0000, 32'h0064_0000, 1'b1);
    settle();

    sent = 0;
    while (sent < 80) begin
      steps = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 511) : $urandom_range(1, 20);
      set_tree(pick_factor(1'b1), pick_factor(1'b0), pick_unit(), pick_unit(), steps);
      no_gaps = ($urandom_range(0, 3) == 0);
      count = (steps > 64) ? 2 : $urandom_range(4, 12);
      repeat (count) begin
        if ($urandom_range(0, 15) == 0) settle();
        if ($urandom_range(0, 3) == 0) begin
          s = $urandom();
          k = $urandom();
        end else begin
          s = $urandom_range(32'h0001_0000, 32'h00C8_0000);
          k = $urandom_range(s >> 1, s + (s >> 1));
        end
        send_request(s, k, 1'($urandom_range(0, 1)));
        sent++;
      end
      settle();
    end

    repeat (20) @(posedge clk);
    $display("Priced %0d requests over %0d tree settings: steps 0 to 511, zero and full-scale",
             board.checked, tree_settings);
    $display("factors, clamped probability and discount, saturated prices, calls and puts.");
    if (board.pending() != 0) begin
      $display("%0d expected prices never arrived", board.pending());
    end
    if (board.failures == 0 && board.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
